// ===== sv/mmcs_pkg.sv =====
// Shared types and constants for the min/max contrast stretch unit.
// Holds the controller state type, the command and status structs and the fixed widths.
// No dependencies.
package mmcs_pkg;

   // Fixed field widths.
   localparam int PIX_IN_W  = 16;   // width of the pixel field on the ports
   localparam int VAL_W     = 17;   // signed pixel value and grey-level register width
   localparam int SPAN_W    = 18;   // span, difference and range width
   localparam int NUM_W     = 36;   // numerator and quotient magnitude width
   localparam int RES_W     = 37;   // signed quotient width before saturation
   localparam int DIV_STEPS = 18;   // number of divider steps, two quotient bits per cycle
   localparam int CNT_W     = 5;    // divider step counter width

   // Configuration register indexes.
   localparam logic [1:0] CSR_PIXEL_SIGNED = 2'd0;
   localparam logic [1:0] CSR_OUT_MIN      = 2'd1;
   localparam logic [1:0] CSR_OUT_MAX      = 2'd2;

   // Function codes carried with each pixel.
   localparam logic FUNC_MEASURE = 1'b0;
   localparam logic FUNC_MAP     = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_FIX
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic measure;    // update running minimum and maximum
      logic capture;    // capture a map pixel and its operands
      logic mul;        // register both products
      logic add;        // form the numerator and load the divider
      logic div;        // one divider step
      logic out_load;   // load the result register
   } cmd_type;

   // Status toward the controller.
   typedef struct packed {
      logic req_valid;  // an input transaction is offered
      logic req_map;    // the offered pixel belongs to the map pass
      logic special;    // full range or flat image, no division needed
      logic out_free;   // the result register can take a new result
   } status_type;

endpackage

// ===== sv/mmcs_ctrl.sv =====
// Controller state machine for the min/max contrast stretch unit.
// Sequences capture, multiply, add, divide and result load for map pixels,
// skipping the arithmetic in the special case. Depends on mmcs_pkg.
module mmcs_ctrl
   import mmcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // State and divider step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = '0;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (status.req_valid) begin
               if (status.req_map) begin
                  cmd.capture = 1'b1;
                  state_in    = status.special ? ST_FIX : ST_MUL;
               end else begin
                  cmd.measure = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIX;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FIX: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A result is loaded only when the output register is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output register busy");

   // At most one datapath command at a time.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

   // The last divider cycle leads to the result state.
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_LAST) |=> state_ff == ST_FIX)
      else $error("divider did not finish into result state");

   // A map pixel that needs division goes on to the multiply state.
   a_map_mul: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && !status.special) |=> state_ff == ST_MUL)
      else $error("map pixel did not start the multiply");

endmodule

// ===== sv/mmcs_dp.sv =====
// Datapath for the min/max contrast stretch unit: running min/max, products,
// a radix-4 restoring divider, saturation and the result register.
// Depends on mmcs_pkg.
module mmcs_dp
   import mmcs_pkg::*;
#(
   parameter int PIXEL_BITS = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic                       pixel_signed,
   input  logic signed [VAL_W-1:0]    out_min,
   input  logic signed [VAL_W-1:0]    out_max,
   input  logic                       req_start,
   input  logic [PIX_IN_W-1:0]        req_pixel,
   input  logic                       req_last,
   output logic                       special,
   output logic [PIX_IN_W-1:0]        rsp_pixel,
   output logic                       rsp_flat,
   output logic                       rsp_last
);

   localparam int PW = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;
   localparam logic signed [RES_W-1:0] ONE_R  = RES_W'(1);
   localparam logic signed [RES_W-1:0] HI_SGN = (ONE_R <<< (PW - 1)) - ONE_R;
   localparam logic signed [RES_W-1:0] LO_SGN = -(ONE_R <<< (PW - 1));
   localparam logic signed [RES_W-1:0] HI_UNS = (ONE_R <<< PW) - ONE_R;

   logic signed [VAL_W-1:0]  min_ff, min_in, max_ff, max_in;
   logic signed [VAL_W-1:0]  x;
   logic                     full_range, flat;
   logic signed [SPAN_W-1:0] diff_now, span_now, range_now;

   logic                     pass_ff, flat_ff, last_ff, neg_ff;
   logic [PIX_IN_W-1:0]      bits_ff;
   logic signed [VAL_W-1:0]  omin_ff;
   logic [SPAN_W-1:0]        span_ff;
   logic signed [SPAN_W-1:0] diff_ff, range_ff;
   logic signed [NUM_W-1:0]  p1_ff, p2_ff, p1_in, p2_in, num;
   logic signed [SPAN_W:0]   span_sg;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [SPAN_W-1:0]        rem_ff, rem_in;
   logic [SPAN_W:0]          r1, r2;
   logic [SPAN_W-1:0]        rem1;
   logic                     b1, b2;
   logic signed [RES_W-1:0]  qs, val, sat;
   logic signed [RES_W-1:0]  lo, hi;
   logic [PIX_IN_W-1:0]      res_pixel;

   // Pixel value: low PW bits, sign-extended when pixels are signed.
   always_comb begin
      for (int i = 0; i < VAL_W; i++) begin
         if (i < PW) begin
            x[i] = req_pixel[i];
         end else begin
            x[i] = pixel_signed & req_pixel[PW-1];
         end
      end
   end

   // Running minimum and maximum.
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (req_start) begin
         min_in = x;
         max_in = x;
      end else begin
         if (x < min_ff) min_in = x;
         if (x > max_ff) max_in = x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
      end else if (cmd.measure) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // Special cases and operands seen at capture.
   assign full_range = (max_ff == out_max) && (min_ff == out_min);
   assign flat       = (max_ff == min_ff);
   assign special    = full_range | flat;
   assign diff_now   = SPAN_W'(x) - SPAN_W'(min_ff);
   assign span_now   = SPAN_W'(max_ff) - SPAN_W'(min_ff);
   assign range_now  = SPAN_W'(out_max) - SPAN_W'(out_min);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pass_ff  <= full_range;
         flat_ff  <= flat & ~full_range;
         last_ff  <= req_last;
         bits_ff  <= req_pixel;
         omin_ff  <= out_min;
         span_ff  <= span_now;
         diff_ff  <= diff_now;
         range_ff <= range_now;
      end
   end

   // Products: out_min * span and (x - min) * range.
   assign span_sg = signed'({1'b0, span_ff});
   assign p1_in   = NUM_W'(omin_ff) * NUM_W'(span_sg);
   assign p2_in   = NUM_W'(diff_ff) * NUM_W'(range_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   // Numerator, then two restoring divider steps per cycle on its magnitude.
   assign num = p1_ff + p2_ff;

   always_comb begin
      r1 = {rem_ff, quo_ff[NUM_W-1]};
      b1 = (r1 >= {1'b0, span_ff});
      rem1 = b1 ? SPAN_W'(r1 - {1'b0, span_ff}) : SPAN_W'(r1);
      r2 = {rem1, quo_ff[NUM_W-2]};
      b2 = (r2 >= {1'b0, span_ff});
      rem_in = b2 ? SPAN_W'(r2 - {1'b0, span_ff}) : SPAN_W'(r2);
      quo_in = {quo_ff[NUM_W-3:0], b1, b2};
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         neg_ff <= num[NUM_W-1];
         quo_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         rem_ff <= '0;
      end else if (cmd.div) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Signed quotient truncated toward zero, then saturation to the pixel type.
   assign qs = signed'({1'b0, quo_ff});
   assign lo = pixel_signed ? LO_SGN : '0;
   assign hi = pixel_signed ? HI_SGN : HI_UNS;

   always_comb begin
      if (flat_ff) begin
         val = RES_W'(omin_ff);
      end else if (neg_ff) begin
         val = -qs;
      end else begin
         val = qs;
      end
      if (val < lo) begin
         sat = lo;
      end else if (val > hi) begin
         sat = hi;
      end else begin
         sat = val;
      end
      if (pass_ff) begin
         res_pixel = PIX_IN_W'(bits_ff[PW-1:0]);
      end else begin
         res_pixel = PIX_IN_W'(sat[PW-1:0]);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pixel <= res_pixel;
         rsp_flat  <= flat_ff;
         rsp_last  <= last_ff;
      end
   end

endmodule

// ===== sv/min_max_contrast_stretch_unit.sv =====
// Min/max contrast stretch: measure pass pixels update the running min/max and give
// no result. A map pixel goes through capture, multiply, add, the divider steps at
// two quotient bits each and saturation before its result is loaded; the result
// load waits for a free output, and the next pixel is taken only after it.
// A full-range or flat image skips the arithmetic and goes from capture to the load.
// Synchronous active-high reset clears control and running min/max and resets configuration.
module min_max_contrast_stretch_unit
   import mmcs_pkg::*;
#(
   parameter int PIXEL_BITS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [15:0] pixel
   input  logic [1:0]           req_tuser,   // [0] func, [1] start_req
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [15:0] mapped_pixel
   output logic                 rsp_tuser,   // [0] flat_image
   output logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [VAL_W-1:0]     csr_wdata
);

   logic                    pixel_signed_ff;
   logic signed [VAL_W-1:0] out_min_ff, out_max_ff;
   logic                    rsp_valid_ff;
   status_type              status;
   cmd_type                 cmd;
   logic                    special;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_signed_ff <= 1'b0;
         out_min_ff      <= '0;
         out_max_ff      <= VAL_W'(65535);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PIXEL_SIGNED: pixel_signed_ff <= csr_wdata[0];
            CSR_OUT_MIN:      out_min_ff      <= signed'(csr_wdata);
            CSR_OUT_MAX:      out_max_ff      <= signed'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Output valid: set on a result load, cleared when the transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign status.req_valid = req_tvalid;
   assign status.req_map   = (req_tuser[0] == FUNC_MAP);
   assign status.special   = special;
   assign status.out_free  = ~rsp_valid_ff | rsp_tready;

   mmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   mmcs_dp #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .pixel_signed (pixel_signed_ff),
      .out_min      (out_min_ff),
      .out_max      (out_max_ff),
      .req_start    (req_tuser[1]),
      .req_pixel    (req_tdata),
      .req_last     (req_tlast),
      .special      (special),
      .rsp_pixel    (rsp_tdata),
      .rsp_flat     (rsp_tuser),
      .rsp_last     (rsp_tlast)
   );

endmodule
